>>> rtl/tpps_pkg.sv
package tpps_pkg;

    // op codes on s_tuser
    localparam logic [1:0] OP_EMIT  = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // 9.8 in Q16.16, rounded to nearest
    localparam logic [19:0] GRAVITY_Q16 = 20'd642253;

    localparam int IN_DATA_W  = 216;
    localparam int OUT_DATA_W = 208;

    typedef enum logic [1:0] {
        K_EMIT  = 2'd0,
        K_TICK  = 2'd1,
        K_CLEAR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [19:0]        dt;
    } cmd_t;

    typedef struct packed {
        logic [16:0] damp;
        logic [19:0] grav;
        logic [23:0] life;
        logic [23:0] width;
    } cfg_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [31:0]        age;
        logic [31:0]        max_life;
    } entry_t;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sh007FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -40'sh0080000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/tpps_front.sv
module tpps_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tpps_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic [1:0]                   s_tuser,
    output logic                         cmd_valid,
    output tpps_pkg::cmd_t               cmd,
    input  logic                         cmd_pop
);

    tpps_pkg::cmd_t q_reg [2];
    logic           wp_reg;
    logic           rp_reg;
    logic [1:0]     cnt_reg;
    logic           known;
    tpps_pkg::cmd_t dec;
    logic           push;

    // classify: unknown op is taken and dropped
    always_comb begin
        known    = 1'b1;
        dec.kind = tpps_pkg::K_EMIT;
        unique case (s_tuser)
            tpps_pkg::OP_EMIT:  dec.kind = tpps_pkg::K_EMIT;
            tpps_pkg::OP_TICK:  dec.kind = tpps_pkg::K_TICK;
            tpps_pkg::OP_CLEAR: dec.kind = tpps_pkg::K_CLEAR;
            default:            known    = 1'b0;
        endcase
        dec.pos_x = s_tdata[31:0];
        dec.pos_y = s_tdata[63:32];
        dec.pos_z = s_tdata[95:64];
        dec.vel_x = s_tdata[127:96];
        dec.vel_y = s_tdata[159:128];
        dec.vel_z = s_tdata[191:160];
        dec.dt    = s_tdata[211:192];
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready && known;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wp_reg] <= dec;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wp_reg <= ~wp_reg;
            end
            if (cmd_pop) begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, cmd_pop};
        end
    end

endmodule

>>> rtl/tpps_back.sv
module tpps_back #(
    parameter int MAX_PARTICLES = 16,
    localparam int SW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1,
    localparam int CW = $clog2(MAX_PARTICLES + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tpps_pkg::cfg_t                cfg,
    input  logic                          cmd_valid,
    input  tpps_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tpps_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                          m_tlast,
    output logic [CW-1:0]                 live_count,
    output logic [SW-1:0]                 oldest
);

    localparam int SUMW = CW + 1;

    localparam logic [39:0] GRAV_EXT = {20'b0, tpps_pkg::GRAVITY_Q16};

    typedef enum logic [10:0] {
        S_IDLE = 11'b00000000001,
        S_G1   = 11'b00000000010,
        S_G2   = 11'b00000000100,
        S_G3   = 11'b00000001000,
        S_ARD  = 11'b00000010000,
        S_AMUL = 11'b00000100000,
        S_AVEL = 11'b00001000000,
        S_APOS = 11'b00010000000,
        S_AWR  = 11'b00100000000,
        S_ORD  = 11'b01000000000,
        S_OLAT = 11'b10000000000
    } state_t;

    // sequencer
    typedef enum logic [2:0] {
        P_NONE = 3'b001,
        P_DIV  = 3'b010,
        P_OUT  = 3'b100
    } phase_t;

    state_t state_reg;
    phase_t phase_reg;

    tpps_pkg::entry_t mem [MAX_PARTICLES];
    tpps_pkg::entry_t rd_q;
    tpps_pkg::entry_t wd;
    tpps_pkg::entry_t ent_reg;
    logic             we;
    logic [SW-1:0]    wa;

    logic [SW-1:0] oldest_reg;
    logic [CW-1:0] live_reg;
    logic [SW-1:0] ptr_reg;
    logic [CW-1:0] idx_reg;
    logic [CW-1:0] drop_reg;
    logic [SW-1:0] keep_reg;
    logic          prefix_reg;
    logic [19:0]   dt_reg;
    logic [39:0]   g1_reg;
    logic [39:0]   plo_reg;
    logic [39:0]   phi_reg;
    logic [28:0]   gdt_reg;
    logic signed [49:0] mvx_reg, mvy_reg, mvz_reg;
    logic signed [31:0] vx_reg, vy_reg, vz_reg;
    logic [31:0]   age_reg;
    logic signed [52:0] px_reg, py_reg, pz_reg;
    logic [31:0]   rem_reg;
    logic [15:0]   q_reg;
    logic [3:0]    bit_reg;
    logic          sat_reg;
    logic          ov_reg;
    logic [tpps_pkg::OUT_DATA_W-1:0] od_reg;
    logic          ol_reg;

    logic [SUMW-1:0] slot_sum;
    logic [SW-1:0]   emit_slot;
    logic            full;
    logic [32:0]     age_sum;
    logic signed [31:0] vy_damp;
    logic signed [31:0] nx, ny, nz;
    logic            drop_now;
    logic [CW-1:0]   drop_next;
    logic [SW-1:0]   keep_next;
    logic [CW-1:0]   live_left;
    logic [32:0]     r2;
    logic            ge;
    logic            out_free;
    logic signed [39:0] xe, ye, half;
    logic [tpps_pkg::OUT_DATA_W-1:0] tri_data;
    logic            is_last;

    function automatic logic [SW-1:0] ptr_inc(input logic [SW-1:0] p);
        return (p == SW'(MAX_PARTICLES - 1)) ? '0 : p + 1'b1;
    endfunction

    assign live_count = live_reg;
    assign oldest     = oldest_reg;
    assign m_tvalid   = ov_reg;
    assign m_tdata    = od_reg;
    assign m_tlast    = ol_reg;

    assign cmd_pop  = (state_reg == S_IDLE) && cmd_valid;
    assign full     = (live_reg == CW'(MAX_PARTICLES));
    assign slot_sum = SUMW'(oldest_reg) + SUMW'(live_reg);
    assign emit_slot = full ? oldest_reg :
        ((slot_sum >= SUMW'(MAX_PARTICLES)) ? SW'(slot_sum - SUMW'(MAX_PARTICLES))
                                            : SW'(slot_sum));

    // advance arithmetic
    assign age_sum = {1'b0, ent_reg.age} + {13'b0, dt_reg};
    assign vy_damp = tpps_pkg::sat32({{6{mvy_reg[49]}}, mvy_reg[49:16]});
    assign nx = tpps_pkg::sat32({{8{ent_reg.pos_x[31]}}, ent_reg.pos_x}
                                + {{3{px_reg[52]}}, px_reg[52:16]});
    assign ny = tpps_pkg::sat32({{8{ent_reg.pos_y[31]}}, ent_reg.pos_y}
                                + {{3{py_reg[52]}}, py_reg[52:16]});
    assign nz = tpps_pkg::sat32({{8{ent_reg.pos_z[31]}}, ent_reg.pos_z}
                                + {{3{pz_reg[52]}}, pz_reg[52:16]});

    // removal of the aged-out oldest prefix, found during the advance walk
    assign drop_now  = prefix_reg && (age_reg >= {8'b0, cfg.life});
    assign drop_next = drop_now ? drop_reg + 1'b1 : drop_reg;
    assign keep_next = drop_now ? ptr_inc(ptr_reg) : keep_reg;
    assign live_left = live_reg - drop_next;

    // one quotient bit a cycle
    assign r2 = {rem_reg, 1'b0};
    assign ge = (r2 >= {1'b0, ent_reg.max_life});

    // triangle
    assign xe   = {{8{ent_reg.pos_x[31]}}, ent_reg.pos_x};
    assign ye   = {{8{ent_reg.pos_y[31]}}, ent_reg.pos_y};
    assign half = {17'b0, cfg.width[23:1]};
    assign tri_data = {sat_reg ? 16'hFFFF : q_reg,
                       ent_reg.pos_z,
                       tpps_pkg::sat32(ye + {16'b0, cfg.width}),
                       ent_reg.pos_y,
                       ent_reg.pos_x,
                       tpps_pkg::sat32(xe + half),
                       tpps_pkg::sat32(xe - half)};
    assign is_last  = (idx_reg == live_reg - 1'b1);
    assign out_free = !ov_reg || m_tready;

    // write port: emit from idle, write-back at the end of an advance
    always_comb begin
        we = 1'b0;
        wa = emit_slot;
        wd.pos_x    = cmd.pos_x;
        wd.pos_y    = cmd.pos_y;
        wd.pos_z    = cmd.pos_z;
        wd.vel_x    = cmd.vel_x;
        wd.vel_y    = cmd.vel_y;
        wd.vel_z    = cmd.vel_z;
        wd.age      = '0;
        wd.max_life = {8'b0, cfg.life};
        if (state_reg == S_AWR) begin
            we = 1'b1;
            wa = ptr_reg;
            wd = '{nx, ny, nz, vx_reg, vy_reg, vz_reg, age_reg, ent_reg.max_life};
        end else if (cmd_pop && (cmd.kind == tpps_pkg::K_EMIT)) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_q <= mem[ptr_reg];
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            S_IDLE: dt_reg <= cmd.dt;
            S_G1:   g1_reg <= GRAV_EXT * {20'b0, cfg.grav};
            S_G2: begin
                plo_reg <= {20'b0, g1_reg[19:0]} * {20'b0, dt_reg};
                phi_reg <= {20'b0, g1_reg[39:20]} * {20'b0, dt_reg};
            end
            S_G3: gdt_reg <= 29'(({phi_reg, 20'b0} + {20'b0, plo_reg}) >> 32);
            S_AMUL: begin
                ent_reg <= rd_q;
                mvx_reg <= rd_q.vel_x * $signed({1'b0, cfg.damp});
                mvy_reg <= rd_q.vel_y * $signed({1'b0, cfg.damp});
                mvz_reg <= rd_q.vel_z * $signed({1'b0, cfg.damp});
            end
            S_AVEL: begin
                age_reg <= age_sum[32] ? 32'hFFFFFFFF : age_sum[31:0];
                vx_reg  <= tpps_pkg::sat32({{6{mvx_reg[49]}}, mvx_reg[49:16]});
                vz_reg  <= tpps_pkg::sat32({{6{mvz_reg[49]}}, mvz_reg[49:16]});
                vy_reg  <= tpps_pkg::sat32({{8{vy_damp[31]}}, vy_damp}
                                           - {11'b0, gdt_reg});
            end
            S_APOS: begin
                px_reg <= vx_reg * $signed({1'b0, dt_reg});
                py_reg <= vy_reg * $signed({1'b0, dt_reg});
                pz_reg <= vz_reg * $signed({1'b0, dt_reg});
            end
            S_OLAT: begin
                if (phase_reg == P_NONE) begin
                    ent_reg <= rd_q;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            phase_reg  <= P_NONE;
            oldest_reg <= '0;
            live_reg   <= '0;
            ptr_reg    <= '0;
            idx_reg    <= '0;
            drop_reg   <= '0;
            keep_reg   <= '0;
            prefix_reg <= 1'b0;
            ov_reg     <= 1'b0;
        end else begin
            // a new triangle loaded in the output phase takes over the register
            if (ov_reg && m_tready && !(state_reg == S_OLAT && phase_reg == P_OUT)) begin
                ov_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (cmd_pop) begin
                        unique case (cmd.kind)
                            tpps_pkg::K_EMIT: begin
                                if (full) begin
                                    oldest_reg <= ptr_inc(oldest_reg);
                                end else begin
                                    live_reg <= live_reg + 1'b1;
                                end
                            end
                            tpps_pkg::K_TICK: state_reg <= S_G1;
                            tpps_pkg::K_CLEAR: begin
                                live_reg   <= '0;
                                oldest_reg <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_G1: state_reg <= S_G2;
                S_G2: state_reg <= S_G3;
                S_G3: begin
                    ptr_reg    <= oldest_reg;
                    keep_reg   <= oldest_reg;
                    idx_reg    <= '0;
                    drop_reg   <= '0;
                    prefix_reg <= 1'b1;
                    state_reg  <= (live_reg == '0) ? S_IDLE : S_ARD;
                end
                S_ARD:  state_reg <= S_AMUL;
                S_AMUL: state_reg <= S_AVEL;
                S_AVEL: state_reg <= S_APOS;
                S_APOS: state_reg <= S_AWR;
                S_AWR: begin
                    drop_reg   <= drop_next;
                    keep_reg   <= keep_next;
                    prefix_reg <= drop_now;
                    if (idx_reg == live_reg - 1'b1) begin
                        live_reg   <= live_left;
                        oldest_reg <= keep_next;
                        ptr_reg    <= keep_next;
                        idx_reg    <= '0;
                        state_reg  <= (live_left == '0) ? S_IDLE : S_ORD;
                    end else begin
                        ptr_reg   <= ptr_inc(ptr_reg);
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_ARD;
                    end
                end
                S_ORD: begin
                    state_reg <= S_OLAT;
                    phase_reg <= P_NONE;
                end
                S_OLAT: begin
                    unique case (phase_reg)
                        P_NONE: begin
                            rem_reg   <= rd_q.age;
                            sat_reg   <= (rd_q.age >= rd_q.max_life);
                            q_reg     <= '0;
                            bit_reg   <= '0;
                            phase_reg <= (rd_q.age >= rd_q.max_life) ? P_OUT : P_DIV;
                        end
                        P_DIV: begin
                            rem_reg <= ge ? 32'(r2 - {1'b0, ent_reg.max_life}) : r2[31:0];
                            q_reg   <= {q_reg[14:0], ge};
                            bit_reg <= bit_reg + 1'b1;
                            if (bit_reg == 4'd15) begin
                                phase_reg <= P_OUT;
                            end
                        end
                        P_OUT: begin
                            if (out_free) begin
                                ov_reg <= 1'b1;
                                od_reg <= tri_data;
                                ol_reg <= is_last;
                                if (is_last) begin
                                    state_reg <= S_IDLE;
                                end else begin
                                    ptr_reg   <= ptr_inc(ptr_reg);
                                    idx_reg   <= idx_reg + 1'b1;
                                    state_reg <= S_ORD;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/trail_particle_pool_step_top.sv
// Trail particle pool: keeps up to MAX_PARTICLES particles oldest first in an
// on-chip memory and steps them in Q16.16 fixed point. Each transfer on the
// s_ side carries an op in s_tuser: emit appends a particle (dropping the
// oldest when full), tick ages, damps, applies gravity and moves every
// particle, removes oldest particles while they are at or above life_span,
// then sends one triangle per live particle on the m_ side, oldest first,
// with m_tlast on the final one; clear empties the pool; op 3 is taken and
// ignored. A two-entry command queue sits between the input and the
// sequencer. A tick first does the advance walk, one read-modify-write of
// memory per particle, then the triangle pass; this runs the one-bit-a-cycle
// age divider for each particle whose age is below its lifetime, skips it
// for the rest and can stall on m_tready. The user must write configuration
// through cfg_we/cfg_addr/cfg_wdata only while the block is idle; the block
// itself does not enforce this.
module trail_particle_pool_step_top #(
    parameter int MAX_PARTICLES = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_we,
    input  logic [1:0]   cfg_addr,
    input  logic [23:0]  cfg_wdata,
    // input transfers
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, delta_time, 4 bits zero pad
    input  logic [215:0] s_tdata,
    // op
    input  logic [1:0]   s_tuser,
    // result transfers
    output logic         m_tvalid,
    input  logic         m_tready,
    // left_x, right_x, center_x, base_y, top_y, depth_z, age_ratio
    output logic [207:0] m_tdata,
    output logic         m_tlast
);

    localparam int SW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    // register indexes
    localparam logic [1:0] REG_DAMP  = 2'd0;
    localparam logic [1:0] REG_GRAV  = 2'd1;
    localparam logic [1:0] REG_LIFE  = 2'd2;
    localparam logic [1:0] REG_WIDTH = 2'd3;

    tpps_pkg::cfg_t cfg_reg;
    tpps_pkg::cmd_t cmd;
    logic           cmd_valid;
    logic           cmd_pop;
    logic [CW-1:0]  live_count;
    logic [SW-1:0]  oldest;

    // configuration registers, masked to their widths
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.damp  <= 17'd62259;
            cfg_reg.grav  <= 20'd13107;
            cfg_reg.life  <= 24'd196608;
            cfg_reg.width <= 24'd131072;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_DAMP:  cfg_reg.damp  <= cfg_wdata[16:0];
                REG_GRAV:  cfg_reg.grav  <= cfg_wdata[19:0];
                REG_LIFE:  cfg_reg.life  <= cfg_wdata;
                REG_WIDTH: cfg_reg.width <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // front: accept, classify, queue
    tpps_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // back: pool memory, integrator, triangle output
    tpps_back #(
        .MAX_PARTICLES (MAX_PARTICLES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_pop    (cmd_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .live_count (live_count),
        .oldest     (oldest)
    );

    // pool never holds more than its capacity
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_count <= CW'(MAX_PARTICLES))
        else $error("live count above capacity");

    // oldest pointer stays inside the pool
    a_oldest_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        oldest <= SW'(MAX_PARTICLES - 1))
        else $error("oldest slot out of range");

    // reset leaves no result pending
    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a command is only taken from the queue when one is there
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd_pop |-> cmd_valid)
        else $error("pop from empty queue");

endmodule
